>>> design/rms_current_meter_macros.svh
// Assertion macros shared by the RMS current meter modules.
`ifndef RMS_CURRENT_METER_MACROS_SVH
`define RMS_CURRENT_METER_MACROS_SVH

// Same-cycle implication, checked on clk and disabled during rst.
`define RCM_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("rms current meter check failed");

// Next-cycle implication, checked on clk and disabled during rst.
`define RCM_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("rms current meter check failed");

`endif

>>> design/rcm_pkg.sv
// Package for the RMS current meter: widths, register codes and control structs.
package rcm_pkg;

  localparam int SAMPLE_BITS = 12;
  localparam int OFFSET_BITS = 12;
  localparam int LEN_BITS    = 13;
  localparam int GAIN_BITS   = 16;
  localparam int FIELD_BITS  = 16;
  localparam int RMS_SHIFT   = 8;
  localparam int GAIN_FRAC   = 12;

  localparam int CFG_IDX_BITS  = 2;
  localparam int CFG_DATA_BITS = 16;

  localparam logic [OFFSET_BITS-1:0] OFFSET_RESET = OFFSET_BITS'(2048);
  localparam logic [LEN_BITS-1:0]    WINDOW_RESET = LEN_BITS'(1000);
  localparam logic [GAIN_BITS-1:0]   GAIN_RESET   = GAIN_BITS'(1115);

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_OFFSET = 2'd0,
    CFG_WINDOW = 2'd1,
    CFG_GAIN   = 2'd2
  } cfg_index_t;

  typedef logic [SAMPLE_BITS-1:0] sample_t;
  typedef logic [FIELD_BITS-1:0]  field_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;
    logic div_step;
    logic root_load;
    logic root_step;
    logic scale;
    logic emit;
  } rcm_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic window_end;
    logic step_last;
  } rcm_status_t;

endpackage

>>> design/rcm_sample_if.sv
// Sample channel: one converter reading per item.
interface rcm_sample_if;
  import rcm_pkg::*;

  logic    valid;
  logic    ready;
  sample_t sample_code;

  modport source (output valid, output sample_code, input ready);
  modport sink   (input valid, input sample_code, output ready);
endinterface

>>> design/rcm_result_if.sv
// Result channel: one RMS measurement per item.
interface rcm_result_if;
  import rcm_pkg::*;

  logic   valid;
  logic   ready;
  field_t rms_code;
  field_t current_ma;

  modport source (output valid, output rms_code, output current_ma, input ready);
  modport sink   (input valid, input rms_code, input current_ma, output ready);
endinterface

>>> design/rms_current_meter.sv
// Windowed RMS current meter: top level joining the controller and the datapath.
//
// Each sample item has the offset code removed, is squared and is added to a
// running sum, one item per clock cycle. When the window is full the sum, scaled
// by 256, is divided by the window length in a restoring divider that makes one
// quotient bit a cycle, and its integer square root is then taken one bit a
// cycle; rms_code carries four fraction bits and current_ma is rms_code times
// current_gain over 4096, both saturated at 65535. The sample that closes a
// window stops intake while the division, root, scaling and emission run; the
// dividend has DivdBits = 2*12 + clog2(min(MAX_WINDOW, 8191)) + 8 bits and the
// root RootBits, half of that rounded up. Intake also waits when a result is
// ready while the previous one has not yet been taken. A window length of zero
// acts as one, a length above MAX_WINDOW acts as MAX_WINDOW, and registers are
// to be written only while the block is idle.

module rms_current_meter #(
  parameter int MAX_WINDOW = 4096
) (
  input  logic                              clk,
  input  logic                              rst,
  rcm_sample_if.sink                        sample,
  rcm_result_if.source                      result,
  input  logic                              cfg_we,
  input  logic [rcm_pkg::CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [rcm_pkg::CFG_DATA_BITS-1:0] cfg_data
);
  import rcm_pkg::*;

  rcm_cmd_t    cmd;
  rcm_status_t status;
  logic        in_ready;
  logic        out_valid;
  field_t      rms_code;
  field_t      current_ma;

  rcm_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (sample.valid),
    .out_ready (result.ready),
    .status    (status),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .cmd       (cmd)
  );

  rcm_datapath #(
    .MAX_WINDOW (MAX_WINDOW)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .sample_code (sample.sample_code),
    .cmd         (cmd),
    .status      (status),
    .rms_code    (rms_code),
    .current_ma  (current_ma)
  );

  assign sample.ready      = in_ready;
  assign result.valid      = out_valid;
  assign result.rms_code   = rms_code;
  assign result.current_ma = current_ma;

endmodule

>>> design/rcm_ctrl.sv
// Controller of the RMS current meter: sequences accumulation, division, root and scaling.
`include "rms_current_meter_macros.svh"

module rcm_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  input  logic                 out_ready,
  input  rcm_pkg::rcm_status_t status,
  output logic                 in_ready,
  output logic                 out_valid,
  output rcm_pkg::rcm_cmd_t    cmd
);
  import rcm_pkg::*;

  typedef enum logic [5:0] {
    ST_ACCUM     = 6'b000001,
    ST_DIVIDE    = 6'b000010,
    ST_ROOT_INIT = 6'b000100,
    ST_ROOT      = 6'b001000,
    ST_SCALE     = 6'b010000,
    ST_EMIT      = 6'b100000
  } state_t;

  state_t state, state_next;
  logic   out_valid_next;

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      ST_ACCUM: begin
        in_ready   = 1'b1;
        cmd.accept = in_valid;
        if (in_valid && status.window_end) begin
          state_next = ST_DIVIDE;
        end
      end
      ST_DIVIDE: begin
        cmd.div_step = 1'b1;
        if (status.step_last) begin
          state_next = ST_ROOT_INIT;
        end
      end
      ST_ROOT_INIT: begin
        cmd.root_load = 1'b1;
        state_next    = ST_ROOT;
      end
      ST_ROOT: begin
        cmd.root_step = 1'b1;
        if (status.step_last) begin
          state_next = ST_SCALE;
        end
      end
      ST_SCALE: begin
        cmd.scale  = 1'b1;
        state_next = ST_EMIT;
      end
      ST_EMIT: begin
        // The result register is loaded only once the previous item has gone.
        cmd.emit = !out_valid || out_ready;
        if (cmd.emit) begin
          state_next = ST_ACCUM;
        end
      end
      default: begin
        state_next = ST_ACCUM;
      end
    endcase
  end

  assign out_valid_next = cmd.emit || (out_valid && !out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_ACCUM;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  `RCM_ASSERT_NEXT(a_window_end_stalls, cmd.accept && status.window_end, !in_ready)
  `RCM_ASSERT_NEXT(a_emit_shows_result, cmd.emit, out_valid)
  `RCM_ASSERT_IMP(a_one_command, 1'b1, $onehot0({cmd.accept, cmd.div_step, cmd.root_load,
                                                  cmd.root_step, cmd.scale, cmd.emit}))

endmodule

>>> design/rcm_datapath.sv
// Datapath of the RMS current meter: registers, accumulator, divider, root and scaling.
`include "rms_current_meter_macros.svh"

module rcm_datapath #(
  parameter int MAX_WINDOW = 4096
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [rcm_pkg::CFG_IDX_BITS-1:0]    cfg_index,
  input  logic [rcm_pkg::CFG_DATA_BITS-1:0]   cfg_data,
  input  rcm_pkg::sample_t                    sample_code,
  input  rcm_pkg::rcm_cmd_t                   cmd,
  output rcm_pkg::rcm_status_t                status,
  output rcm_pkg::field_t                     rms_code,
  output rcm_pkg::field_t                     current_ma
);
  import rcm_pkg::*;

  localparam int LenMax    = (1 << LEN_BITS) - 1;
  localparam int EffMax    = (MAX_WINDOW > LenMax) ? LenMax : MAX_WINDOW;
  localparam int SumBits   = 2 * SAMPLE_BITS + $clog2(EffMax);
  localparam int DivdBits  = SumBits + RMS_SHIFT;
  localparam int RootBits  = (DivdBits + 1) / 2;
  localparam int RadBits   = 2 * RootBits;
  localparam int SremBits  = RootBits + 2;
  localparam int StepBits  = $clog2(DivdBits);
  localparam int ProdBits  = FIELD_BITS + GAIN_BITS;
  localparam int MaBits    = ProdBits - GAIN_FRAC;
  localparam logic [LEN_BITS-1:0] LenCap = LEN_BITS'(EffMax);

  // Configuration registers.
  logic [OFFSET_BITS-1:0] offset_code;
  logic [LEN_BITS-1:0]    window_length;
  logic [GAIN_BITS-1:0]   current_gain;

  // Window state.
  logic [SumBits-1:0]  square_sum;
  logic [LEN_BITS-1:0] samples_taken;

  // Division, root and scaling work registers.
  logic [DivdBits-1:0] divd;
  logic [LEN_BITS-1:0] rem;
  logic [LEN_BITS-1:0] div_len;
  logic [StepBits-1:0] step_cnt;
  logic [RadBits-1:0]  rad;
  logic [RootBits-1:0] root;
  logic [SremBits-1:0] srem;
  field_t              rms;
  field_t              rms_code_q;
  field_t              current_ma_q;

  logic [SAMPLE_BITS-1:0]   mag;
  logic [2*SAMPLE_BITS-1:0] sq;
  logic [SumBits-1:0]       sum_add;
  logic [LEN_BITS-1:0]      eff_len;
  logic [LEN_BITS:0]        count_inc;
  logic [LEN_BITS:0]        div_trial;
  logic [LEN_BITS:0]        div_diff;
  logic                     div_ge;
  logic [SremBits+1:0]      root_acc;
  logic [SremBits+1:0]      root_trial;
  logic [SremBits+1:0]      root_diff;
  logic                     root_ge;
  logic [ProdBits-1:0]      prod;
  logic [MaBits-1:0]        ma_wide;

  // Accumulation: offset removal, square and window test.
  always_comb begin
    if (sample_code >= offset_code) begin
      mag = sample_code - offset_code;
    end else begin
      mag = offset_code - sample_code;
    end
    sq      = mag * mag;
    sum_add = square_sum + {{(SumBits - 2*SAMPLE_BITS){1'b0}}, sq};

    // A zero length counts as one; the length is capped at the window maximum.
    if (window_length == '0) begin
      eff_len = LEN_BITS'(1);
    end else if (window_length > LenCap) begin
      eff_len = LenCap;
    end else begin
      eff_len = window_length;
    end
    count_inc         = {1'b0, samples_taken} + (LEN_BITS+1)'(1);
    status.window_end = count_inc >= {1'b0, eff_len};
    status.step_last  = step_cnt == '0;
  end

  // One quotient bit per step, restoring division.
  always_comb begin
    div_trial = {rem, divd[DivdBits-1]};
    div_diff  = div_trial - {1'b0, div_len};
    div_ge    = div_trial >= {1'b0, div_len};
  end

  // One root bit per step, two radicand bits brought down each time.
  always_comb begin
    root_acc   = {srem, rad[RadBits-1 -: 2]};
    root_trial = {2'b00, root, 2'b01};
    root_diff  = root_acc - root_trial;
    root_ge    = root_acc >= root_trial;
  end

  always_comb begin
    prod    = rms * current_gain;
    ma_wide = prod[ProdBits-1:GAIN_FRAC];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      offset_code   <= OFFSET_RESET;
      window_length <= WINDOW_RESET;
      current_gain  <= GAIN_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_OFFSET: offset_code   <= cfg_data[OFFSET_BITS-1:0];
        CFG_WINDOW: window_length <= cfg_data[LEN_BITS-1:0];
        CFG_GAIN:   current_gain  <= cfg_data[GAIN_BITS-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      square_sum    <= '0;
      samples_taken <= '0;
    end else if (cmd.accept) begin
      if (status.window_end) begin
        square_sum    <= '0;
        samples_taken <= '0;
      end else begin
        square_sum    <= sum_add;
        samples_taken <= count_inc[LEN_BITS-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept && status.window_end) begin
      divd     <= {sum_add, {RMS_SHIFT{1'b0}}};
      rem      <= '0;
      div_len  <= eff_len;
      step_cnt <= StepBits'(DivdBits - 1);
    end
    if (cmd.div_step) begin
      divd     <= {divd[DivdBits-2:0], div_ge};
      rem      <= div_ge ? div_diff[LEN_BITS-1:0] : div_trial[LEN_BITS-1:0];
      step_cnt <= step_cnt - StepBits'(1);
    end
    if (cmd.root_load) begin
      rad      <= RadBits'(divd);
      root     <= '0;
      srem     <= '0;
      step_cnt <= StepBits'(RootBits - 1);
    end
    if (cmd.root_step) begin
      rad      <= rad << 2;
      root     <= {root[RootBits-2:0], root_ge};
      srem     <= root_ge ? root_diff[SremBits-1:0] : root_acc[SremBits-1:0];
      step_cnt <= step_cnt - StepBits'(1);
    end
    if (cmd.scale) begin
      rms <= (|root[RootBits-1:FIELD_BITS]) ? '1 : root[FIELD_BITS-1:0];
    end
    if (cmd.emit) begin
      rms_code_q   <= rms;
      current_ma_q <= (|ma_wide[MaBits-1:FIELD_BITS]) ? '1 : ma_wide[FIELD_BITS-1:0];
    end
  end

  assign rms_code   = rms_code_q;
  assign current_ma = current_ma_q;

  `RCM_ASSERT_IMP(a_count_in_range, 1'b1, samples_taken < LenCap)
  `RCM_ASSERT_NEXT(a_rem_below_len, cmd.div_step, rem < div_len)
  `RCM_ASSERT_NEXT(a_zero_rms_zero_ma, cmd.emit && rms == '0, current_ma == '0)

endmodule
